[rtl/rmct_pkg.sv]
// Package for the region map clip-and-translate block.
// Holds request/result payload types, command codes and table sizes.
// No dependencies; every rtl file refers to it by scoped names.
`timescale 1ns / 1ps
package rmct_pkg;

  localparam int MaxEntries = 16;
  localparam int TargetBits = 8;
  localparam int IdxW       = $clog2(MaxEntries);
  localparam int CntW       = $clog2(MaxEntries + 1);
  localparam int QueueDepth = 2;

  localparam logic [7:0] TargetMask = 8'((1 << TargetBits) - 1);

  localparam logic [1:0] ActClear  = 2'd0;
  localparam logic [1:0] ActInsert = 2'd1;
  localparam logic [1:0] ActXlate  = 2'd2;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusUnmapped = 2'd1;
  localparam logic [1:0] StatusFull     = 2'd2;

  typedef enum logic [1:0] {
    KIND_CLEAR,
    KIND_INSERT,
    KIND_XLATE,
    KIND_NOP
  } kind_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] start_address;
    logic [63:0] span_length;
    logic [7:0]  target_id;
    logic [63:0] target_base_offset;
    logic        write_access;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  chunk_target;
    logic [63:0] chunk_target_address;
    logic [63:0] chunk_length;
    logic        chunk_is_write;
    logic        last;
  } res_t;

  // Classified request handed from front to back.
  typedef struct packed {
    kind_e       kind;
    logic [63:0] addr;
    logic [63:0] len;
    logic [63:0] end_addr;
    logic        len_zero;
    logic [7:0]  tgt;
    logic [63:0] off;
    logic        wr;
  } cmd_t;

endpackage

[rtl/rmct_front.sv]
// Front end: accepts requests, decodes the action, saturates the region end
// and buffers classified commands in a short queue. Uses rmct_pkg.
`timescale 1ns / 1ps
module rmct_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rmct_pkg::req_t in_req_i,
  output logic          cmd_valid_o,
  input  logic          cmd_pop_i,
  output rmct_pkg::cmd_t cmd_o
);

  localparam int PtrW = $clog2(rmct_pkg::QueueDepth);

  rmct_pkg::cmd_t q_mem_q [rmct_pkg::QueueDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [PtrW:0]   count_q;
  rmct_pkg::cmd_t  cls;
  logic [64:0]     sum;
  logic            push;

  assign in_stall_o  = (count_q == (PtrW+1)'(rmct_pkg::QueueDepth));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = q_mem_q[rptr_q];
  assign push        = in_valid_i && !in_stall_o;

  always_comb begin
    sum          = {1'b0, in_req_i.start_address} + {1'b0, in_req_i.span_length};
    cls.addr     = in_req_i.start_address;
    cls.len      = in_req_i.span_length;
    cls.end_addr = sum[64] ? '1 : sum[63:0];
    cls.len_zero = (in_req_i.span_length == '0);
    cls.tgt      = in_req_i.target_id & rmct_pkg::TargetMask;
    cls.off      = in_req_i.target_base_offset;
    cls.wr       = in_req_i.write_access;
    case (in_req_i.action)
      rmct_pkg::ActClear:  cls.kind = rmct_pkg::KIND_CLEAR;
      rmct_pkg::ActInsert: cls.kind = rmct_pkg::KIND_INSERT;
      rmct_pkg::ActXlate:  cls.kind = rmct_pkg::KIND_XLATE;
      default:             cls.kind = rmct_pkg::KIND_NOP;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (cmd_pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      count_q <= count_q + (PtrW+1)'(push) - (PtrW+1)'(cmd_pop_i);
    end
  end

endmodule

[rtl/rmct_back.sv]
// Back end: region table, insert clipping engine, access translation engine
// and the output result register. Uses rmct_pkg.
`timescale 1ns / 1ps
module rmct_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_pop_o,
  input  rmct_pkg::cmd_t cmd_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rmct_pkg::res_t out_res_o
);

  localparam int N    = rmct_pkg::MaxEntries;
  localparam int IdxW = rmct_pkg::IdxW;
  localparam int CntW = rmct_pkg::CntW;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SIChk  = 4'd1;
  localparam logic [3:0] SIScan = 4'd2;
  localparam logic [3:0] SIAct  = 4'd3;
  localparam logic [3:0] STChk  = 4'd4;
  localparam logic [3:0] STScan = 4'd5;
  localparam logic [3:0] STCal1 = 4'd6;
  localparam logic [3:0] STCal2 = 4'd7;
  localparam logic [3:0] SEmit  = 4'd8;

  logic [3:0]      state_q, state_d;
  logic [N-1:0]    valid_q, valid_d;
  logic [N-1:0]    pend_q, pend_d;
  logic [63:0]     ebase_q [N];
  logic [63:0]     eend_q  [N];
  logic [7:0]      etgt_q  [N];
  logic [63:0]     eoff_q  [N];

  rmct_pkg::cmd_t  cmd_q, cmd_d;
  logic [63:0]     cur_q, cur_d;
  logic [63:0]     len_q, len_d;
  logic [63:0]     nb_q, nb_d;
  logic            hit_q, hit_d;
  logic [63:0]     hbase_q, hbase_d;
  logic [63:0]     hend_q, hend_d;
  logic [63:0]     hoff_q, hoff_d;
  logic [7:0]      htgt_q, htgt_d;
  logic [63:0]     o_q, o_d;
  logic [63:0]     avail_q, avail_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CntW-1:0] k_q, k_d;
  logic            more_q, more_d;
  rmct_pkg::res_t  res_q, res_d;
  rmct_pkg::res_t  out_q;
  logic            out_valid_q, out_valid_d;
  logic            out_load;

  logic            free_found;
  logic [IdxW-1:0] free_idx;
  logic            wr_en;
  logic            idx_last;
  logic            scan_live;
  logic [63:0]     n_len;

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign idx_last    = (idx_q == IdxW'(N - 1));
  assign scan_live   = valid_q[idx_q] && !pend_q[idx_q];
  assign n_len       = (len_q < avail_q) ? len_q : avail_q;

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    pend_d      = pend_q;
    cmd_d       = cmd_q;
    cur_d       = cur_q;
    len_d       = len_q;
    nb_d        = nb_q;
    hit_d       = hit_q;
    hbase_d     = hbase_q;
    hend_d      = hend_q;
    hoff_d      = hoff_q;
    htgt_d      = htgt_q;
    o_d         = o_q;
    avail_d     = avail_q;
    idx_d       = idx_q;
    k_d         = k_q;
    more_d      = more_q;
    res_d       = res_q;
    cmd_pop_o   = 1'b0;
    wr_en       = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      SIdle: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          cur_d     = cmd_i.addr;
          len_d     = cmd_i.len;
          more_d    = 1'b0;
          k_d       = '0;
          res_d     = '0;
          res_d.last = 1'b1;
          case (cmd_i.kind)
            rmct_pkg::KIND_CLEAR: begin
              valid_d = '0;
              state_d = SEmit;
            end
            rmct_pkg::KIND_INSERT: begin
              pend_d  = '0;
              state_d = SIChk;
            end
            rmct_pkg::KIND_XLATE: begin
              res_d.chunk_is_write = cmd_i.wr;
              state_d = cmd_i.len_zero ? SEmit : STChk;
            end
            default: state_d = SEmit;
          endcase
        end
      end

      SIChk: begin
        if (cur_q >= cmd_q.end_addr) begin
          // Commit the stored fragments.
          pend_d  = '0;
          state_d = SEmit;
        end else begin
          idx_d   = '0;
          hit_d   = 1'b0;
          nb_d    = cmd_q.end_addr;
          state_d = SIScan;
        end
      end

      SIScan: begin
        if (scan_live) begin
          if (cur_q >= ebase_q[idx_q] && cur_q < eend_q[idx_q]) begin
            hit_d  = 1'b1;
            hend_d = eend_q[idx_q];
          end else if (cur_q < ebase_q[idx_q] && ebase_q[idx_q] < nb_q) begin
            nb_d = ebase_q[idx_q];
          end
        end
        idx_d = idx_q + 1'b1;
        if (idx_last) begin
          state_d = SIAct;
        end
      end

      SIAct: begin
        if (hit_q) begin
          cur_d   = hend_q;
          state_d = SIChk;
        end else if (!free_found) begin
          // Drop every fragment of this insert.
          valid_d      = valid_q & ~pend_q;
          pend_d       = '0;
          res_d.status = rmct_pkg::StatusFull;
          state_d      = SEmit;
        end else begin
          wr_en             = 1'b1;
          valid_d[free_idx] = 1'b1;
          pend_d[free_idx]  = 1'b1;
          cur_d             = nb_q;
          state_d           = SIChk;
        end
      end

      STChk: begin
        if (k_q == CntW'(N)) begin
          res_d.status               = rmct_pkg::StatusUnmapped;
          res_d.chunk_target         = '0;
          res_d.chunk_target_address = '0;
          res_d.chunk_length         = '0;
          more_d                     = 1'b0;
          res_d.last                 = 1'b1;
          state_d                    = SEmit;
        end else begin
          idx_d   = '0;
          hit_d   = 1'b0;
          state_d = STScan;
        end
      end

      STScan: begin
        if (valid_q[idx_q] && cur_q >= ebase_q[idx_q] && cur_q < eend_q[idx_q]) begin
          hit_d   = 1'b1;
          hbase_d = ebase_q[idx_q];
          hend_d  = eend_q[idx_q];
          hoff_d  = eoff_q[idx_q];
          htgt_d  = etgt_q[idx_q];
        end
        idx_d = idx_q + 1'b1;
        if (idx_last) begin
          state_d = STCal1;
        end
      end

      STCal1: begin
        if (!hit_q) begin
          res_d.status               = rmct_pkg::StatusUnmapped;
          res_d.chunk_target         = '0;
          res_d.chunk_target_address = '0;
          res_d.chunk_length         = '0;
          res_d.last                 = 1'b1;
          more_d                     = 1'b0;
          state_d                    = SEmit;
        end else begin
          o_d     = cur_q - hbase_q;
          avail_d = hend_q - cur_q;
          state_d = STCal2;
        end
      end

      STCal2: begin
        res_d.status               = rmct_pkg::StatusOk;
        res_d.chunk_target         = htgt_q;
        res_d.chunk_target_address = hoff_q + o_q;
        res_d.chunk_length         = n_len;
        res_d.last                 = (len_q <= avail_q);
        more_d                     = (len_q > avail_q);
        state_d                    = SEmit;
      end

      SEmit: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          if (more_q) begin
            len_d   = len_q - res_q.chunk_length;
            cur_d   = cur_q + res_q.chunk_length;
            k_d     = k_q + 1'b1;
            state_d = STChk;
          end else begin
            state_d = SIdle;
          end
        end
      end

      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ebase_q[free_idx] <= cur_q;
      eend_q[free_idx]  <= nb_q;
      etgt_q[free_idx]  <= cmd_q.tgt;
      eoff_q[free_idx]  <= cmd_q.off + (cur_q - cmd_q.addr);
    end
    if (out_load) begin
      out_q <= res_q;
    end
    cmd_d_reg: begin
      cmd_q   <= cmd_d;
      cur_q   <= cur_d;
      len_q   <= len_d;
      nb_q    <= nb_d;
      hbase_q <= hbase_d;
      hend_q  <= hend_d;
      hoff_q  <= hoff_d;
      htgt_q  <= htgt_d;
      o_q     <= o_d;
      avail_q <= avail_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      valid_q     <= '0;
      pend_q      <= '0;
      hit_q       <= 1'b0;
      idx_q       <= '0;
      k_q         <= '0;
      more_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      idx_q       <= idx_d;
      k_q         <= k_d;
      more_q      <= more_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/region_map_clip_and_translate_top.sv]
// Top level of the region map clip-and-translate block.
// Connects rmct_front and rmct_back; uses rmct_pkg.
//
// Usage: one request channel (in_valid_i / in_stall_o / in_req_i) carries
// clear, insert and translate requests; one result channel (out_valid_o /
// out_stall_i / out_res_o) returns their results in order. Clear and insert
// give one result each; a translate gives one result per region crossed, up
// to 16 chunks, plus a final unmapped result if a gap or the chunk limit is
// hit. The last flag marks the final result of every request.
// Timing: the front decodes and queues up to two requests. The back walks
// the 16 table entries one per cycle for every insert or translate step;
// the entry scan sets the rate.
// Reset empties the table and the queue and drops any pending result.
// While the receiver stalls, the result register holds and the back engine
// waits to emit; the queue keeps accepting until it is full.
`timescale 1ns / 1ps
module region_map_clip_and_translate_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rmct_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rmct_pkg::res_t out_res_o
);

  logic           cmd_valid;
  logic           cmd_pop;
  rmct_pkg::cmd_t cmd;

  rmct_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  rmct_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

endmodule

[rtl/rmct_checker.sv]
// Port-level checks for the region map clip-and-translate top level.
// Uses rmct_pkg; bound to region_map_clip_and_translate_top below.
`timescale 1ns / 1ps
module rmct_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input rmct_pkg::res_t out_res_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_res_o))
    else $error("stalled result changed");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.status != rmct_pkg::StatusOk |-> out_res_o.last)
    else $error("error result not marked last");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.status == rmct_pkg::StatusFull |->
      out_res_o.chunk_length == '0 && out_res_o.chunk_is_write == 1'b0)
    else $error("table full result carries chunk data");

  a_unmapped_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.status == rmct_pkg::StatusUnmapped |->
      out_res_o.chunk_length == '0 && out_res_o.chunk_target_address == '0)
    else $error("unmapped result carries chunk data");

endmodule

bind region_map_clip_and_translate_top rmct_checker u_rmct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_res_o   (out_res_o)
);

[tb/tb_region_map_clip_and_translate_top.sv]
// Testbench for the region map clip-and-translate block.
// Drives clear/insert/translate requests, predicts results and checks them in order.
// Depends on rmct_pkg and region_map_clip_and_translate_top.
`timescale 1ns / 1ps
module tb_region_map_clip_and_translate_top;
  import rmct_pkg::*;

  localparam logic [63:0] AddrMax = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int WatchLimit = 20000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  req_t in_req_i;
  logic out_valid_o;
  logic out_stall_i;
  res_t out_res_o;

  region_map_clip_and_translate_top dut (.*);

  // Predicted table state.
  logic        tbl_valid  [MaxEntries];
  logic [63:0] tbl_base   [MaxEntries];
  logic [63:0] tbl_size   [MaxEntries];
  logic [7:0]  tbl_target [MaxEntries];
  logic [63:0] tbl_offset [MaxEntries];

  req_t pending_reqs[$];
  res_t expected_results[$];
  int   mismatches;
  int   watchdog;
  bit   stim_done;
  bit   idle_enable;
  bit   hold_sender;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic res_t make_res(logic [1:0] st, logic [7:0] tg, logic [63:0] ta,
                                    logic [63:0] ln, logic wr, logic lst);
    res_t r;
    r.status = st;
    r.chunk_target = tg;
    r.chunk_target_address = ta;
    r.chunk_length = ln;
    r.chunk_is_write = wr;
    r.last = lst;
    return r;
  endfunction

  function automatic logic [1:0] clip_insert(logic [63:0] base, logic [63:0] size,
                                             logic [7:0] tgt, logic [63:0] off);
    logic [63:0] fb[$], fs[$], fo[$];
    logic [63:0] nb[$], ns[$], no[$];
    logic [63:0] send, eb, ee, pb, pe;
    int free_slots, j;
    if (size == 0) return StatusOk;
    send = base + size;
    if (send < base) send = AddrMax;
    if (send - base == 0) return StatusOk;
    fb = {fb, base}; fs = {fs, send - base}; fo = {fo, off};
    for (int i = 0; i < MaxEntries && fb.size() > 0; i++) begin
      if (!tbl_valid[i]) continue;
      eb = tbl_base[i];
      ee = eb + tbl_size[i];
      nb.delete(); ns.delete(); no.delete();
      for (int k = 0; k < fb.size(); k++) begin
        pb = fb[k];
        pe = pb + fs[k];
        if (pe <= eb || ee <= pb) begin
          nb = {nb, pb}; ns = {ns, fs[k]}; no = {no, fo[k]};
          continue;
        end
        if (pb < eb) begin
          nb = {nb, pb}; ns = {ns, eb - pb}; no = {no, fo[k]};
        end
        if (pe > ee) begin
          nb = {nb, ee}; ns = {ns, pe - ee}; no = {no, fo[k] + (ee - pb)};
        end
      end
      fb = nb; fs = ns; fo = no;
    end
    if (fb.size() == 0) return StatusOk;
    free_slots = 0;
    for (int i = 0; i < MaxEntries; i++) if (!tbl_valid[i]) free_slots++;
    if (fb.size() > free_slots) return StatusFull;
    j = 0;
    for (int i = 0; i < MaxEntries && j < fb.size(); i++) begin
      if (tbl_valid[i]) continue;
      tbl_valid[i] = 1'b1;
      tbl_base[i] = fb[j];
      tbl_size[i] = fs[j];
      tbl_target[i] = tgt & TargetMask;
      tbl_offset[i] = fo[j];
      j++;
    end
    return StatusOk;
  endfunction

  // Work out the results of one accepted request and update the table.
  task automatic predict_request(req_t rq);
    logic [63:0] addr, len, o, avail, n;
    int hit, chunks;
    case (rq.action)
      ActClear: begin
        for (int i = 0; i < MaxEntries; i++) tbl_valid[i] = 1'b0;
        expected_results = {expected_results, make_res(StatusOk, 0, 0, 0, 0, 1)};
      end
      ActInsert: expected_results = {expected_results, make_res(
          clip_insert(rq.start_address, rq.span_length, rq.target_id,
                      rq.target_base_offset), 0, 0, 0, 0, 1)};
      ActXlate: begin
        addr = rq.start_address;
        len = rq.span_length;
        chunks = 0;
        if (len == 0)
          expected_results = {expected_results, make_res(StatusOk, 0, 0, 0,
                                                          rq.write_access, 1)};
        while (len > 0) begin
          hit = -1;
          for (int i = 0; i < MaxEntries; i++)
            if (hit < 0 && tbl_valid[i] && addr >= tbl_base[i] &&
                addr < tbl_base[i] + tbl_size[i]) hit = i;
          if (hit < 0 || chunks >= MaxEntries) begin
            expected_results = {expected_results, make_res(StatusUnmapped, 0, 0, 0,
                                                            rq.write_access, 1)};
            break;
          end
          o = addr - tbl_base[hit];
          avail = tbl_size[hit] - o;
          n = (len < avail) ? len : avail;
          len -= n;
          expected_results = {expected_results, make_res(StatusOk, tbl_target[hit],
                                                          tbl_offset[hit] + o, n,
                                                          rq.write_access, len == 0)};
          chunks++;
          addr += n;
        end
      end
      default: expected_results = {expected_results, make_res(StatusOk, 0, 0, 0, 0, 1)};
    endcase
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic req_t build_req(logic [1:0] act, logic [63:0] a, logic [63:0] l,
                                     logic [7:0] t, logic [63:0] off, logic wr);
    req_t r;
    r.action = act;
    r.start_address = a;
    r.span_length = l;
    r.target_id = t;
    r.target_base_offset = off;
    r.write_access = wr;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) predict_request(in_req_i);
      if (pending_reqs.size() > 0 && !hold_sender &&
          !(idle_enable && $urandom_range(99) < 26)) begin
        in_valid_i <= 1'b1;
        in_req_i <= pending_reqs.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall and result check.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      watchdog <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_res_o.chunk_length, 64'd0);
        end else begin
          res_t w;
          w = expected_results.pop_front();
          if (out_res_o.status != w.status) report_mismatch("status", out_res_o.status, w.status);
          if (out_res_o.chunk_target != w.chunk_target)
            report_mismatch("chunk_target", out_res_o.chunk_target, w.chunk_target);
          if (out_res_o.chunk_target_address != w.chunk_target_address)
            report_mismatch("chunk_target_address", out_res_o.chunk_target_address,
                            w.chunk_target_address);
          if (out_res_o.chunk_length != w.chunk_length)
            report_mismatch("chunk_length", out_res_o.chunk_length, w.chunk_length);
          if (out_res_o.chunk_is_write != w.chunk_is_write)
            report_mismatch("chunk_is_write", out_res_o.chunk_is_write, w.chunk_is_write);
          if (out_res_o.last != w.last) report_mismatch("last", out_res_o.last, w.last);
        end
      end
      out_stall_i <= idle_enable && ($urandom_range(99) < 26);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (watchdog >= WatchLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic add_region(logic [63:0] a, logic [63:0] l, logic [7:0] t, logic [63:0] off);
    pending_reqs = {pending_reqs, build_req(ActInsert, a, l, t, off, $urandom_range(1))};
  endtask

  task automatic add_access(logic [63:0] a, logic [63:0] l, logic wr);
    pending_reqs = {pending_reqs, build_req(ActXlate, a, l, rand64(), rand64(), wr)};
  endtask

  // A clear, then random small regions in one window, then accesses into it.
  task automatic add_random_scene(int n_acc);
    logic [63:0] win;
    win = ($urandom_range(3) == 0) ? AddrMax - 64'd4000 : {$urandom(), 32'h0};
    pending_reqs = {pending_reqs, build_req(ActClear, rand64(), rand64(), rand64(),
                                            rand64(), $urandom_range(1))};
    repeat ($urandom_range(9, 1))
      add_region(win + $urandom_range(3000), $urandom_range(800), $urandom(), rand64());
    repeat (n_acc)
      add_access(win + $urandom_range(3600), $urandom_range(900), $urandom_range(1));
  endtask

  initial begin
    mismatches = 0;
    stim_done = 1'b0;
    idle_enable = 1'b0;
    hold_sender = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    out_stall_i = 1'b0;
    for (int i = 0; i < MaxEntries; i++) tbl_valid[i] = 1'b0;

    // Directed: extremes, overlap clipping, saturation, gaps, full table.
    add_access(64'd0, 64'd0, 1'b1);
    add_access(AddrMax, AddrMax, 1'b0);
    add_region(64'h1000, 64'd0, 8'hFF, AddrMax);
    add_region(64'h1000, 64'h100, 8'hFF, AddrMax - 64'h10);
    add_region(64'h0F80, 64'h200, 8'h00, 64'h5000);
    add_region(64'h1020, 64'h40, 8'h11, 64'h0);
    add_access(64'h0F80, 64'h200, 1'b1);
    add_access(64'h0F00, 64'h100, 1'b0);
    add_access(64'h1170, 64'h40, 1'b1);
    add_region(AddrMax - 64'h20, AddrMax, 8'hA5, 64'h77);
    add_access(AddrMax - 64'h30, 64'h40, 1'b1);
    pending_reqs = {pending_reqs, build_req(2'd3, AddrMax, AddrMax, 8'hFF, AddrMax, 1'b1)};
    pending_reqs = {pending_reqs, build_req(ActClear, AddrMax, AddrMax, 8'hFF, AddrMax,
                                            1'b1)};
    for (int i = 0; i < 9; i++) add_region(64'h100 * i, 64'h10, i, 64'h10 * i);
    add_region(64'h0, 64'h1000, 8'h3C, 64'h9000);
    add_access(64'h0, 64'h1000, 1'b0);
    add_region(64'h0, 64'h2000, 8'h3C, 64'h0);

    while (pending_reqs.size() < 420) begin
      if ($urandom_range(9) == 0) begin
        pending_reqs = {pending_reqs, build_req($urandom_range(3), rand64(), rand64(),
                                                $urandom(), rand64(), $urandom_range(1))};
      end else begin
        add_random_scene(6);
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Unbroken stretch first, then random idling, with one drain pause.
    wait (pending_reqs.size() < 330);
    idle_enable = 1'b1;
    wait (pending_reqs.size() < 200);
    @(posedge clk_i);
    hold_sender = 1'b1;
    wait (expected_results.size() == 0 && !in_valid_i);
    repeat (40) @(posedge clk_i);
    hold_sender = 1'b0;

    wait (pending_reqs.size() == 0 && !in_valid_i);
    wait (expected_results.size() == 0);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[region_map_clip_and_translate_top.f]
rtl/rmct_pkg.sv
rtl/rmct_front.sv
rtl/rmct_back.sv
rtl/region_map_clip_and_translate_top.sv
rtl/rmct_checker.sv
tb/tb_region_map_clip_and_translate_top.sv
